### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge, disabled while reset is asserted.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hw/rtl/rphc_pkg.sv
// Types, codes and reset values for the reflow profile heater controller.
package rphc_pkg;

  localparam int unsigned TempW  = 13;
  localparam int unsigned RampW  = 30;
  localparam int unsigned DegW   = 10;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned ActW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 30;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 16;

  // Reset values of the configuration registers.
  localparam logic [RampW-1:0] PreheatRampRst = 30'd63068260;
  localparam logic [RampW-1:0] SoakRampRst    = 30'd63119510;
  localparam logic [RampW-1:0] ReflowRampRst  = 30'd42189020;
  localparam logic [DegW-1:0]  CoolExitRst    = 10'd40;
  localparam logic [DegW-1:0]  IdleHotRst     = 10'd60;
  localparam logic [DutyW-1:0] HoldDutyRst    = 8'd30;
  localparam logic [DutyW-1:0] FullDutyRst    = 8'd254;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PREHEAT_RAMP = 3'd0,
    CFG_SOAK_RAMP    = 3'd1,
    CFG_REFLOW_RAMP  = 3'd2,
    CFG_COOL_EXIT    = 3'd3,
    CFG_IDLE_HOT     = 3'd4,
    CFG_HOLD_DUTY    = 3'd5,
    CFG_FULL_DUTY    = 3'd6
  } cfg_idx_e;

  typedef enum logic [ActW-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Phase machine state, one-hot.
  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_PREHEAT = 5'b00010,
    PH_SOAK    = 5'b00100,
    PH_REFLOW  = 5'b01000,
    PH_COOLING = 5'b10000
  } phase_e;

  // Phase codes as seen on the result word.
  localparam logic [PhaseW-1:0] PhCodeIdle    = 3'd0;
  localparam logic [PhaseW-1:0] PhCodePreheat = 3'd1;
  localparam logic [PhaseW-1:0] PhCodeSoak    = 3'd2;
  localparam logic [PhaseW-1:0] PhCodeReflow  = 3'd3;
  localparam logic [PhaseW-1:0] PhCodeCooling = 3'd4;

  // Packed ramp register: min degC, max degC, min dwell seconds.
  typedef struct packed {
    logic [DegW-1:0] secs;
    logic [DegW-1:0] hi;
    logic [DegW-1:0] lo;
  } ramp_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    unique case (ph)
      PH_IDLE:    code = PhCodeIdle;
      PH_PREHEAT: code = PhCodePreheat;
      PH_SOAK:    code = PhCodeSoak;
      PH_REFLOW:  code = PhCodeReflow;
      PH_COOLING: code = PhCodeCooling;
      default:    code = PhCodeIdle;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/reflow_profile_heater_controller_unit.sv
// Top level of the reflow profile heater controller.
//
// Usage:
//   s_axis carries one word per event: tuser is the action (tick with a
//   temperature sample, start run, stop run), tdata the oven temperature in
//   quarter degC, signed. Every accepted word yields exactly one result word
//   on m_axis: heater duty, phase code and the running flag.
//   Configuration (ramps, temperatures, duties) is written through
//   cfg_we_i / cfg_idx_i / cfg_data_i while no word is in flight.
// Timing:
//   Two stages: an input register, then the phase/dwell/duty update that
//   loads the result register. A word moves from the input register into
//   the result register once the result register is free; one word per
//   cycle is sustained while m_axis_tready stays high.
// Reset:
//   rst_ni clears the phase machine to idle, dwell, duty and run mark to zero,
//   empties both stages and loads the default configuration.
// Stall:
//   While m_axis_tready is low the result word holds; the input register
//   still takes a word when it is empty, then s_axis_tready drops.
`include "assert_macros.svh"

module reflow_profile_heater_controller_unit
  import rphc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [12:0] temperature, zero fill above
  input  logic [ActW-1:0]      s_axis_tuser,   // [1:0] action
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [7:0] duty, [10:8] phase, [11] running
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned CalcW = 15;  // covers 2*(lo+hi) - temperature

  // ---------------- configuration registers ----------------
  ramp_t            preheat_q, soak_q, reflow_q;
  logic [DegW-1:0]  cool_exit_q, idle_hot_q;
  logic [DutyW-1:0] hold_duty_q, full_duty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preheat_q   <= ramp_t'(PreheatRampRst);
      soak_q      <= ramp_t'(SoakRampRst);
      reflow_q    <= ramp_t'(ReflowRampRst);
      cool_exit_q <= CoolExitRst;
      idle_hot_q  <= IdleHotRst;
      hold_duty_q <= HoldDutyRst;
      full_duty_q <= FullDutyRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PREHEAT_RAMP: preheat_q   <= ramp_t'(cfg_data_i[RampW-1:0]);
        CFG_SOAK_RAMP:    soak_q      <= ramp_t'(cfg_data_i[RampW-1:0]);
        CFG_REFLOW_RAMP:  reflow_q    <= ramp_t'(cfg_data_i[RampW-1:0]);
        CFG_COOL_EXIT:    cool_exit_q <= cfg_data_i[DegW-1:0];
        CFG_IDLE_HOT:     idle_hot_q  <= cfg_data_i[DegW-1:0];
        CFG_HOLD_DUTY:    hold_duty_q <= cfg_data_i[DutyW-1:0];
        CFG_FULL_DUTY:    full_duty_q <= cfg_data_i[DutyW-1:0];
        default: ;  // index beyond the register list: dropped
      endcase
    end
  end

  // ---------------- handshake / stage control ----------------
  logic             in_vld_q;
  logic [ActW-1:0]  in_act_q;
  logic [TempW-1:0] in_temp_q;
  logic             out_vld_q;
  logic             advance;  // result register free for a new word
  logic             fire;     // stage two processes the held word

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_act_q  <= s_axis_tuser;
      in_temp_q <= s_axis_tdata[TempW-1:0];
    end
  end

  // ---------------- controller state ----------------
  phase_e           phase_q, phase_d;
  logic             dwell_act_q, dwell_act_d;
  logic [DegW-1:0]  dwell_sec_q, dwell_sec_d;
  logic [DutyW-1:0] duty_q, duty_d;
  logic             started_q, started_d;

  // Ramp of the current heating phase.
  ramp_t ramp;
  always_comb begin
    unique case (phase_q)
      PH_SOAK:   ramp = soak_q;
      PH_REFLOW: ramp = reflow_q;
      default:   ramp = preheat_q;
    endcase
  end

  // Temperature compares, all in quarter degC.
  logic signed [CalcW-1:0] tq, lo_s, hi_s, range_s, delta_s, mag_s;
  logic signed [CalcW-1:0] lo4, hot4, exit4;
  logic [DegW-1:0]         sec_inc;
  logic                    dwell_done;

  always_comb begin
    tq      = CalcW'(signed'(in_temp_q));
    lo_s    = CalcW'(ramp.lo);
    hi_s    = CalcW'(ramp.hi);
    range_s = hi_s - lo_s;
    delta_s = ((lo_s + hi_s) <<< 1) - tq;  // band center minus reading
    mag_s   = delta_s[CalcW-1] ? -delta_s : delta_s;
    lo4     = lo_s <<< 2;
    hot4    = CalcW'(idle_hot_q) <<< 2;
    exit4   = CalcW'(cool_exit_q) <<< 2;
    // dwell counts one second first, saturating
    sec_inc    = (dwell_act_q && (dwell_sec_q != '1)) ? dwell_sec_q + 1'b1 : dwell_sec_q;
    dwell_done = dwell_act_q && (sec_inc >= ramp.secs);
  end

  always_comb begin
    phase_d     = phase_q;
    dwell_act_d = dwell_act_q;
    dwell_sec_d = dwell_sec_q;
    duty_d      = duty_q;
    started_d   = started_q;
    unique case (action_e'(in_act_q))
      ACT_START: begin
        phase_d     = PH_PREHEAT;
        dwell_act_d = 1'b0;
        dwell_sec_d = '0;
        duty_d      = '0;
        started_d   = 1'b1;
      end
      ACT_STOP: begin
        phase_d     = PH_IDLE;
        dwell_act_d = 1'b0;
        dwell_sec_d = '0;
        duty_d      = '0;
        started_d   = 1'b0;
      end
      ACT_TICK: begin
        // hot idle drops into cooling and takes the cooling rule this tick
        if (phase_q == PH_IDLE) begin
          if (tq < hot4) begin
            duty_d = '0;
          end else begin
            phase_d = PH_COOLING;
          end
        end
        unique case (phase_d)
          PH_PREHEAT, PH_SOAK, PH_REFLOW: begin
            if (dwell_done) begin
              unique case (phase_q)
                PH_PREHEAT: phase_d = PH_SOAK;
                PH_SOAK:    phase_d = PH_REFLOW;
                default:    phase_d = PH_COOLING;
              endcase
              dwell_act_d = 1'b0;
              dwell_sec_d = '0;
            end else begin
              if (tq < lo4) begin
                dwell_act_d = 1'b0;
                dwell_sec_d = '0;
              end else if (!dwell_act_q) begin
                dwell_act_d = 1'b1;
                dwell_sec_d = '0;
              end else begin
                dwell_sec_d = sec_inc;
              end
              priority if (mag_s <= range_s) begin
                duty_d = hold_duty_q;
              end else if (delta_s[CalcW-1]) begin
                duty_d = '0;  // above the band
              end else begin
                duty_d = full_duty_q;
              end
            end
          end
          PH_COOLING: begin
            duty_d = '0;
            if (tq < exit4) phase_d = PH_IDLE;
          end
          default: ;
        endcase
      end
      default: ;  // unused action: no change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      dwell_act_q <= 1'b0;
      dwell_sec_q <= '0;
      duty_q      <= '0;
      started_q   <= 1'b0;
    end else if (fire) begin
      phase_q     <= phase_d;
      dwell_act_q <= dwell_act_d;
      dwell_sec_q <= dwell_sec_d;
      duty_q      <= duty_d;
      started_q   <= started_d;
    end
  end

  // ---------------- result register ----------------
  logic [DutyW-1:0]  res_duty_q;
  logic [PhaseW-1:0] res_phase_q;
  logic              res_run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_duty_q  <= duty_d;
      res_phase_q <= phase_code(phase_d);
      res_run_q   <= started_d && (phase_d != PH_IDLE);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutTdataW - DutyW - PhaseW - 1)'(0), res_run_q, res_phase_q,
                          res_duty_q};

  // ---------------- checks ----------------
  `ASSERT_PROP(a_heat_needs_run, clk_i, rst_ni,
    (phase_q == PH_PREHEAT || phase_q == PH_SOAK || phase_q == PH_REFLOW) |-> started_q,
    "heating phase without a started run")
  `ASSERT_PROP(a_dwell_count_active, clk_i, rst_ni,
    (dwell_sec_q != '0) |-> dwell_act_q, "dwell seconds counted while dwell inactive")
  `ASSERT_PROP(a_idle_no_heat, clk_i, rst_ni,
    (phase_q == PH_IDLE) |-> (duty_q == '0), "heater driven while idle")
  `ASSERT_PROP(a_held_word_kept, clk_i, rst_ni,
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_act_q) && $stable(in_temp_q)),
    "input word lost while result stalled")

endmodule

### sim/rphc_checker.sv
// Scoreboard for the heater controller: mirrors the phase machine and checks every result word.
`timescale 1ns / 1ps
module rphc_checker
  import rphc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [12:0] temperature
  input  logic [ActW-1:0]      s_axis_tuser,   // [1:0] action
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata,   // [7:0] duty, [10:8] phase, [11] running
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output int unsigned          mismatch_cnt_o,
  output int unsigned          owed_cnt_o,
  output int unsigned          checked_cnt_o,
  output logic [4:0]           phases_seen_o
);

  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic [PhaseW-1:0] phase;
    logic              running;
  } heat_word_t;

  // register copies
  ramp_t            ramp_q [3];
  logic [DegW-1:0]  cool_exit_q;
  logic [DegW-1:0]  idle_hot_q;
  logic [DutyW-1:0] hold_duty_q;
  logic [DutyW-1:0] full_duty_q;

  // controller state
  logic [PhaseW-1:0] phase_q;
  logic              dwell_on_q;
  logic [DegW-1:0]   dwell_secs_q;
  logic [DutyW-1:0]  duty_q;
  logic              started_q;

  heat_word_t owed_heat_words [$];

  function automatic void clear_run();
    phase_q      = PhCodeIdle;
    dwell_on_q   = 1'b0;
    dwell_secs_q = '0;
    duty_q       = '0;
    started_q    = 1'b0;
  endfunction

  // One tick in a heating phase; tq in quarter degC.
  function automatic void heat_step(ramp_t r, int tq);
    int lo4, span, gap, mag;
    span = int'(r.hi) - int'(r.lo);
    lo4  = 4 * int'(r.lo);
    gap  = lo4 + 2 * span - tq;  // band middle minus reading
    mag  = (gap < 0) ? -gap : gap;
    if (dwell_on_q && dwell_secs_q != '1) dwell_secs_q = dwell_secs_q + 1'b1;
    if (dwell_on_q && dwell_secs_q >= r.secs) begin
      case (phase_q)
        PhCodePreheat: phase_q = PhCodeSoak;
        PhCodeSoak:    phase_q = PhCodeReflow;
        default:       phase_q = PhCodeCooling;
      endcase
      dwell_on_q   = 1'b0;
      dwell_secs_q = '0;
      return;  // duty holds on the advancing tick
    end
    if (tq < lo4) begin
      dwell_on_q   = 1'b0;
      dwell_secs_q = '0;
    end else if (!dwell_on_q) begin
      dwell_on_q   = 1'b1;
      dwell_secs_q = '0;
    end
    // empty band when span < 0: mag never fits
    if (mag <= span) duty_q = hold_duty_q;
    else if (gap < 0) duty_q = '0;
    else duty_q = full_duty_q;
  endfunction

  function automatic heat_word_t next_heat_word(action_e act, int tq);
    heat_word_t w;
    case (act)
      ACT_START: begin
        clear_run();
        phase_q   = PhCodePreheat;
        started_q = 1'b1;
      end
      ACT_STOP: clear_run();
      ACT_TICK: begin
        if (phase_q == PhCodeIdle) begin
          if (tq < 4 * int'(idle_hot_q)) duty_q = '0;
          else phase_q = PhCodeCooling;
        end
        case (phase_q)
          PhCodePreheat: heat_step(ramp_q[0], tq);
          PhCodeSoak:    heat_step(ramp_q[1], tq);
          PhCodeReflow:  heat_step(ramp_q[2], tq);
          PhCodeCooling: begin
            duty_q = '0;
            if (tq < 4 * int'(cool_exit_q)) phase_q = PhCodeIdle;
          end
          default: ;
        endcase
      end
      default: ;  // unused action: nothing moves
    endcase
    w.duty    = duty_q;
    w.phase   = phase_q;
    w.running = started_q && (phase_q != PhCodeIdle);
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    heat_word_t want, got;
    if (!rst_ni) begin
      ramp_q[0]   = PreheatRampRst;
      ramp_q[1]   = SoakRampRst;
      ramp_q[2]   = ReflowRampRst;
      cool_exit_q = CoolExitRst;
      idle_hot_q  = IdleHotRst;
      hold_duty_q = HoldDutyRst;
      full_duty_q = FullDutyRst;
      clear_run();
      owed_heat_words.delete();
      mismatch_cnt_o = 0;
      checked_cnt_o  = 0;
      owed_cnt_o     = 0;
      phases_seen_o  = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_PREHEAT_RAMP: ramp_q[0]   = cfg_data_i;
          CFG_SOAK_RAMP:    ramp_q[1]   = cfg_data_i;
          CFG_REFLOW_RAMP:  ramp_q[2]   = cfg_data_i;
          CFG_COOL_EXIT:    cool_exit_q = cfg_data_i[DegW-1:0];
          CFG_IDLE_HOT:     idle_hot_q  = cfg_data_i[DegW-1:0];
          CFG_HOLD_DUTY:    hold_duty_q = cfg_data_i[DutyW-1:0];
          CFG_FULL_DUTY:    full_duty_q = cfg_data_i[DutyW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = next_heat_word(action_e'(s_axis_tuser),
                              int'($signed(s_axis_tdata[TempW-1:0])));
        phases_seen_o[want.phase] = 1'b1;
        owed_heat_words.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.duty    = m_axis_tdata[7:0];
        got.phase   = m_axis_tdata[10:8];
        got.running = m_axis_tdata[11];
        if (owed_heat_words.size() == 0) begin
          $display("%0t: expected no result word, got %h", $time, m_axis_tdata);
          mismatch_cnt_o++;
        end else begin
          want = owed_heat_words.pop_front();
          checked_cnt_o++;
          if (got !== want) begin
            $display("%0t: duty/phase/running expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     $time, want.duty, want.phase, want.running,
                     got.duty, got.phase, got.running);
            mismatch_cnt_o++;
          end
        end
      end
      owed_cnt_o = owed_heat_words.size();
    end
  end

endmodule

### sim/testbench.sv
// Testbench top for the heater controller: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module testbench;
  import rphc_pkg::*;

  localparam int TempMin     = -400;   // failed sensor reading
  localparam int TempMax     = 4095;
  localparam int DrainCycles = 8;      // result passes through the input and result registers
  localparam int StopAfterNs = 5_000_000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;   // [12:0] temperature, zero fill above
  logic [ActW-1:0]      s_axis_tuser;   // [1:0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;   // [7:0] duty, [10:8] phase, [11] running
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_data_i;

  int unsigned mismatch_cnt;
  int unsigned owed_cnt;
  int unsigned checked_cnt;
  logic [4:0]  phases_seen;

  // Stimulus-side copy of the thresholds, only used to aim temperatures.
  ramp_t           ramp_set [3];
  logic [DegW-1:0] exit_set;
  logic [DegW-1:0] hot_set;

  int unsigned words_sent    = 0;
  int unsigned settings_used = 1;   // reset values count as the first
  int          burst_left    = 0;
  bit [8:0]    stall_tick;

  reflow_profile_heater_controller_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  rphc_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .owed_cnt_o     (owed_cnt),
    .checked_cnt_o  (checked_cnt),
    .phases_seen_o  (phases_seen)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side back-pressure: bits [8:7] of a tick counter rotate the pattern
  // between always ready, mostly ready, coin flip, and long stalls (ready when tick bits [3:0] are zero).
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[8:7])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
      2'd2:    m_axis_tready <= ($urandom_range(0, 1) == 0);
      default: m_axis_tready <= (stall_tick[3:0] == 4'd0);
    endcase
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #StopAfterNs;
    $display("testbench: errors");
    $finish;
  end

  function automatic int clamp_temp(int t);
    return (t < TempMin) ? TempMin : ((t > TempMax) ? TempMax : t);
  endfunction

  // Random reading, with extra weight on the threshold edges and the sign bit.
  function automatic int rand_temp();
    case ($urandom_range(0, 9))
      0:       return TempMin;
      1:       return clamp_temp(4 * int'(hot_set) - int'($urandom_range(0, 1)));
      2:       return clamp_temp(4 * int'(exit_set) - int'($urandom_range(0, 1)));
      3:       return $urandom_range(0, 1) ? TempMax : -1;
      default: return int'($urandom_range(0, 4495)) + TempMin;
    endcase
  endfunction

  function automatic ramp_t mk_ramp(int lo, int hi, int secs);
    ramp_t r;
    r.lo   = lo[DegW-1:0];
    r.hi   = hi[DegW-1:0];
    r.secs = secs[DegW-1:0];
    return r;
  endfunction

  // Short dwell so runs get through all phases; now and then an inverted band.
  function automatic ramp_t fast_ramp(int base);
    int lo, hi;
    lo = base + int'($urandom_range(0, 40));
    hi = ($urandom_range(0, 5) == 0) ? lo - int'($urandom_range(1, 20))
                                     : lo + int'($urandom_range(4, 60));
    return mk_ramp(lo, hi, int'($urandom_range(0, 4)));
  endfunction

  // Sends one word. Words go out in bursts; a new burst may start after a gap.
  task automatic put_word(action_e act, int temp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {{(InTdataW - TempW){1'b0}}, temp[TempW-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act != ACT_NONE) words_sent++;
  endtask

  // Hold off the sender until every owed result word is back.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (owed_cnt != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  // New register set, written only with the block drained.
  task automatic load_setting(ramp_t pre, ramp_t soak, ramp_t refl,
                              int exit_c, int hot_c, int hold, int full);
    settle();
    write_reg(CFG_PREHEAT_RAMP, pre);
    write_reg(CFG_SOAK_RAMP, soak);
    write_reg(CFG_REFLOW_RAMP, refl);
    write_reg(CFG_COOL_EXIT, CfgDataW'(exit_c));
    write_reg(CFG_IDLE_HOT, CfgDataW'(hot_c));
    write_reg(CFG_HOLD_DUTY, CfgDataW'(hold));
    write_reg(CFG_FULL_DUTY, CfgDataW'(full));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ramp_set[0] = pre;
    ramp_set[1] = soak;
    ramp_set[2] = refl;
    exit_set    = exit_c[DegW-1:0];
    hot_set     = hot_c[DegW-1:0];
    settings_used++;
  endtask

  task automatic load_fast();
    load_setting(fast_ramp(30), fast_ramp(120), fast_ramp(200),
                 20 + int'($urandom_range(0, 40)), 40 + int'($urandom_range(0, 50)),
                 int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
  endtask

  // A full run: start, then readings aimed at each heating band in turn (a
  // few dips below the minimum to reset the dwell, a few aborts and stray
  // codes), then a hot spell and a drop below the cooling exit.
  task automatic run_profile();
    int seg, n, lo4, top4;
    put_word(ACT_START, rand_temp());
    for (seg = 0; seg < 3; seg++) begin
      lo4  = 4 * int'(ramp_set[seg].lo);
      top4 = 16 + 4 * ((ramp_set[seg].hi > ramp_set[seg].lo) ? int'(ramp_set[seg].hi)
                                                              : int'(ramp_set[seg].lo));
      n = ((ramp_set[seg].secs > 10) ? 10 : int'(ramp_set[seg].secs))
          + int'($urandom_range(2, 5));
      repeat (n) begin
        case ($urandom_range(0, 39))
          0:       put_word(ACT_STOP, rand_temp());
          1:       put_word(ACT_NONE, rand_temp());
          2:       put_word(ACT_START, rand_temp());
          3, 4, 5: put_word(ACT_TICK, clamp_temp(lo4 - int'($urandom_range(1, 40))));
          default: put_word(ACT_TICK, clamp_temp(int'($urandom_range(lo4, top4))));
        endcase
      end
    end
    repeat ($urandom_range(1, 3))
      put_word(ACT_TICK, clamp_temp(int'($urandom_range(4 * int'(exit_set), TempMax))));
    put_word(ACT_TICK, clamp_temp(4 * int'(exit_set) - int'($urandom_range(1, 60))));
  endtask

  task automatic noise_burst();
    action_e act;
    repeat ($urandom_range(1, 6)) begin
      act = action_e'($urandom_range(0, 3));
      put_word(act, rand_temp());
    end
  endtask

  task automatic play(int unsigned target);
    int unsigned stop_at;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) noise_burst();
      else run_profile();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ACT_TICK;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PREHEAT_RAMP;
    cfg_data_i    = '0;
    ramp_set[0]   = PreheatRampRst;
    ramp_set[1]   = SoakRampRst;
    ramp_set[2]   = ReflowRampRst;
    exit_set      = CoolExitRst;
    hot_set       = IdleHotRst;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset thresholds: preheat 100..150 degC (400..600 q), exit
    // 160 q, hot idle 240 q.
    put_word(ACT_TICK, TempMin);    // failed sensor, idle stays cold
    put_word(ACT_TICK, 0);
    put_word(ACT_TICK, 239);        // just under hot idle
    put_word(ACT_TICK, 240);        // hot idle enters cooling
    put_word(ACT_TICK, TempMax);
    put_word(ACT_TICK, 160);        // at exit: stays cooling
    put_word(ACT_TICK, 159);        // below exit: back to idle
    put_word(ACT_NONE, TempMax);    // unused code, ignored
    put_word(ACT_START, TempMin);
    put_word(ACT_TICK, 399);        // below minimum, full duty
    put_word(ACT_TICK, 400);        // at minimum, dwell starts, still below band
    put_word(ACT_TICK, 450);        // lower band edge, hold duty
    put_word(ACT_TICK, 550);        // upper band edge, hold duty
    put_word(ACT_TICK, 551);        // above band, zero duty
    put_word(ACT_TICK, TempMax);
    put_word(ACT_TICK, -1);         // dip clears the dwell
    put_word(ACT_NONE, 0);          // ignored mid-run
    put_word(ACT_STOP, 0);
    put_word(ACT_TICK, TempMax);    // hot idle after stop: cooling, not running
    put_word(ACT_START, 0);         // start straight out of cooling
    put_word(ACT_STOP, TempMax);

    play(40);

    // short dwells, realistic bands
    load_fast();
    play(150);

    // extremes: inverted preheat, all-zero soak, all-ones reflow
    load_setting(mk_ramp(1023, 0, 0), mk_ramp(0, 0, 0), ramp_t'('1),
                 0, 1023, 0, 255);
    play(60);

    // extremes the other way: idle is hot for readings of 0 q and above, cooling exits below 4092 q
    load_setting(mk_ramp(0, 1023, 1), mk_ramp(500, 100, 2), fast_ramp(200),
                 1023, 0, 255, 0);
    play(60);

    load_fast();
    play(100);
    settle();    // let everything drain mid-phase
    play(100);

    settle();
    $display("summary: %0d words over %0d register settings, %0d result words checked",
             words_sent, settings_used, checked_cnt);
    $display("summary: phases reached (cooling..idle) %b", phases_seen);
    if (mismatch_cnt == 0 && owed_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
